// ----- hdl/substitution_penalty_table_macros.svh -----
`ifndef SUBSTITUTION_PENALTY_TABLE_MACROS_SVH
`define SUBSTITUTION_PENALTY_TABLE_MACROS_SVH
// Assertion helpers for the back part.
`define SPT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/spt_pkg.sv -----
`default_nettype none
package spt_pkg;
  localparam int unsigned MaxSize = 32;
  localparam int unsigned IdxW = $clog2(MaxSize);
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = MaxSize * MaxSize;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned PenW = ScoreW + 1;
  localparam int unsigned SizeW = IdxW + 1;
  // Number of pair penalties at most, n*(n-1).
  localparam int unsigned CntW = AddrW;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdScale = 2'd2;
  localparam logic [1:0] CmdSpare = 2'd3;

  localparam logic [0:0] RegSize = 1'b0;
  localparam logic [0:0] RegUnit = 1'b1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IdxW-1:0]   row;
    logic [IdxW-1:0]   col;
    logic signed [ScoreW-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     kind;
    logic [PenW-1:0]          penalty;
    logic signed [ScoreW-1:0] similarity;
    logic [PenW-1:0]          scale_value;
    logic                     out_of_range;
  } rsp_t;
endpackage
`default_nettype wire

// ----- hdl/spt_if.sv -----
`default_nettype none
interface spt_req_if import spt_pkg::*;;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spt_rsp_if import spt_pkg::*;;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/spt_front.sv -----
`default_nettype none
// Front part: accepts requests, drops unused codes, and queues the rest.
module spt_front import spt_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spt_req_if.sink   req,
  output req_t      q_data_o,
  output logic      q_valid_o,
  input  wire logic q_pop_i
);
  req_t       buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       keep, push;

  assign req.ready = (cnt_q != 2'd2);
  assign keep = (req.data.cmd == CmdWrite) || (req.data.cmd == CmdRead) ||
                (req.data.cmd == CmdScale);
  assign push = req.valid && req.ready && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = buf_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && q_pop_i) cnt_d = cnt_q - 2'd1;
  end

  // Two-entry queue between accept and execution.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_ptr_q] <= req.data;
  end
endmodule
`default_nettype wire

// ----- hdl/spt_back.sv -----
`default_nettype none
`include "substitution_penalty_table_macros.svh"
// Back part: executes queued requests against the score memory.
module spt_back import spt_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic [SizeW-1:0] size_i,
  input  wire logic         unit_i,
  input  req_t              q_data_i,
  input  wire logic         q_valid_i,
  output logic              q_pop_o,
  spt_rsp_if.source         rsp
);
  // States.
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRdAA = 4'd1;
  localparam logic [3:0] StRdBB = 4'd2;
  localparam logic [3:0] StRdAB = 4'd3;
  localparam logic [3:0] StCalc = 4'd4;
  localparam logic [3:0] StOut  = 4'd5;
  localparam logic [3:0] StSPair = 4'd6;
  localparam logic [3:0] StSCmp = 4'd7;
  localparam logic [3:0] StSNext = 4'd8;

  localparam logic [IdxW:0] NOne = (IdxW+1)'(1);
  localparam logic [IdxW:0] NTwo = (IdxW+1)'(2);

  logic [3:0] st_q, st_d;
  logic signed [ScoreW-1:0] mem [Depth];
  logic signed [ScoreW-1:0] rdata_q;
  logic [AddrW-1:0] raddr;
  logic [IdxW-1:0]  a_q, b_q;
  logic signed [ScoreW-1:0] saa_q, sbb_q, sab_q;
  rsp_t out_q;
  rsp_t init_rsp;
  logic out_valid_q;
  logic [SizeW-1:0] n_eff;
  logic [IdxW:0] n_w;
  // Selection walk: candidate (ca,cb), inner (ia,ib).
  logic [IdxW-1:0] ca_q, cb_q, ia_q, ib_q;
  logic            inner_q;
  logic [PenW-1:0] cand_q;
  logic [CntW:0]   lt_q, le_q;
  logic [CntW:0]   rank;
  logic [CntW:0]   npairs;
  logic [PenW-1:0] pen_c;
  logic signed [ScoreW-1:0] sim_c;
  logic signed [ScoreW+2:0] diff;
  logic [IdxW:0] ia_n, ib_n, ca_n, cb_n;
  logic last_inner, found, rd_oor;

  assign n_eff = (size_i > SizeW'(MaxSize)) ? SizeW'(MaxSize) : size_i;
  assign n_w = (IdxW+1)'(n_eff);
  assign npairs = (CntW+1)'(n_eff) * (CntW+1)'(n_eff) - (CntW+1)'(n_eff);
  assign rank = npairs >> 1;

  assign diff = (ScoreW+3)'(saa_q) + (ScoreW+3)'(sbb_q) - ((ScoreW+3)'(sab_q) <<< 1);
  assign pen_c = unit_i ? PenW'(a_q != b_q) :
                 (diff < 0 ? '0 : PenW'(diff));
  assign sim_c = unit_i ? ScoreW'(a_q == b_q) : sab_q;

  always_comb begin
    unique case (st_q) inside
      StRdAA, StSPair: raddr = {a_q, a_q};
      StRdBB: raddr = {b_q, b_q};
      default: raddr = {a_q, b_q};
    endcase
  end

  // Score memory, one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i && !out_valid_q && q_data_i.cmd == CmdWrite)
      mem[{q_data_i.row, q_data_i.col}] <= q_data_i.value;
    rdata_q <= mem[raddr];
  end

  assign ia_n = {1'b0, ia_q};
  assign ib_n = {1'b0, ib_q};
  assign ca_n = {1'b0, ca_q};
  assign cb_n = {1'b0, cb_q};
  // The last off-diagonal pair of the last row closes an inner pass.
  assign last_inner = (ia_n + NOne == n_w) && (ib_n + NTwo == n_w);
  // The candidate is the upper median when its rank interval covers the target rank.
  assign found = (lt_q <= rank) && (le_q > rank);
  assign rd_oor = ({1'b0, q_data_i.row} >= n_eff) || ({1'b0, q_data_i.col} >= n_eff);

  // First contents of a result, before any computed field.
  always_comb begin
    init_rsp = '0;
    init_rsp.kind = (q_data_i.cmd == CmdScale);
    init_rsp.out_of_range = (q_data_i.cmd == CmdRead) && rd_oor;
  end

  always_comb begin
    st_d = st_q;
    q_pop_o = 1'b0;
    unique case (st_q)
      StIdle: if (q_valid_i && !out_valid_q) begin
        q_pop_o = 1'b1;
        if (q_data_i.cmd == CmdRead) st_d = rd_oor ? StOut : StRdAA;
        else if (q_data_i.cmd == CmdScale) st_d = (n_eff < SizeW'(2)) ? StOut : StSPair;
      end
      StRdAA: st_d = StRdBB;
      StRdBB: st_d = StRdAB;
      StRdAB: st_d = StCalc;
      StCalc: st_d = out_q.kind ? StSCmp : StOut;
      StOut: st_d = StIdle;
      StSPair: st_d = StRdBB;
      StSCmp: st_d = inner_q ? StSNext : StSPair;
      StSNext: st_d = (last_inner && found) ? StOut : StSPair;
      default: st_d = StIdle;
    endcase
  end

  // Read path fetches s_aa, s_bb, s_ab; the scale walk reuses it per pair.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      out_valid_q <= 1'b0;
      inner_q <= 1'b0;
    end else begin
      st_q <= st_d;
      out_valid_q <= (st_q == StOut) || (out_valid_q && !rsp.ready);
      unique case (st_q)
        StIdle: if (q_valid_i && !out_valid_q) begin
          out_q <= init_rsp;
          if (q_data_i.cmd == CmdScale) begin
            ca_q <= '0; cb_q <= IdxW'(1);
            ia_q <= '0; ib_q <= IdxW'(1);
            a_q <= '0; b_q <= IdxW'(1);
            inner_q <= 1'b0;
            lt_q <= '0; le_q <= '0;
          end else begin
            a_q <= q_data_i.row;
            b_q <= q_data_i.col;
          end
        end
        StRdBB: saa_q <= rdata_q;
        StRdAB: sbb_q <= rdata_q;
        StCalc: sab_q <= rdata_q;
        StOut: begin
          if (!out_q.kind && !out_q.out_of_range) begin
            out_q <= '{kind: 1'b0, penalty: pen_c, similarity: sim_c,
                       scale_value: '0, out_of_range: 1'b0};
          end
        end
        StSCmp: begin
          // With inner_q low this computes the candidate; the inner pass that follows ranks it.
          if (!inner_q) begin
            cand_q <= pen_c;
            inner_q <= 1'b1;
            ia_q <= '0; ib_q <= IdxW'(1);
            a_q <= '0; b_q <= IdxW'(1);
            lt_q <= '0; le_q <= '0;
          end else begin
            if (pen_c < cand_q) lt_q <= lt_q + 1'b1;
            if (pen_c <= cand_q) le_q <= le_q + 1'b1;
          end
        end
        StSNext: begin
          if (last_inner) begin
            if (found) begin
              out_q <= '{kind: 1'b1, penalty: '0, similarity: '0,
                         scale_value: cand_q, out_of_range: 1'b0};
            end else begin
              inner_q <= 1'b0;
              if (cb_n + NOne == n_w ||
                  (cb_n + NTwo == n_w && ca_n == cb_n + NOne)) begin
                ca_q <= ca_q + 1'b1;
                cb_q <= (ca_q + 1'b1 == '0) ? IdxW'(1) : '0;
                a_q <= ca_q + 1'b1;
                b_q <= '0;
              end else begin
                cb_q <= (cb_q + 1'b1 == ca_q) ? cb_q + IdxW'(2) : cb_q + 1'b1;
                a_q <= ca_q;
                b_q <= (cb_q + 1'b1 == ca_q) ? cb_q + IdxW'(2) : cb_q + 1'b1;
              end
            end
          end else begin
            if (ib_n + NOne == n_w ||
                (ib_n + NTwo == n_w && ia_n == ib_n + NOne)) begin
              ia_q <= ia_q + 1'b1;
              ib_q <= '0;
              a_q <= ia_q + 1'b1;
              b_q <= '0;
            end else begin
              ib_q <= (ib_q + 1'b1 == ia_q) ? ib_q + IdxW'(2) : ib_q + 1'b1;
              a_q <= ia_q;
              b_q <= (ib_q + 1'b1 == ia_q) ? ib_q + IdxW'(2) : ib_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid = out_valid_q;
  assign rsp.data = out_q;

  `SPT_ASSERT_IMPL(a_kind_fields, clk_i, rst_ni, rsp.valid && rsp.data.kind,
                   rsp.data.penalty == '0 && !rsp.data.out_of_range)
  `SPT_ASSERT_IMPL(a_oor_zero, clk_i, rst_ni, rsp.valid && rsp.data.out_of_range,
                   rsp.data.penalty == '0 && rsp.data.similarity == '0)
  `SPT_ASSERT_IMPL(a_no_pop_busy, clk_i, rst_ni, st_q != StIdle, !q_pop_o)
  `SPT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp.valid && !rsp.ready,
                   rsp.valid && $stable(rsp.data))
endmodule
`default_nettype wire

// ----- hdl/substitution_penalty_table.sv -----
`default_nettype none
// Channel | Dir | Payload
// req     | in  | cmd, row, col, value
// rsp     | out | kind, penalty, similarity, scale_value, out_of_range
// A pair read takes the back part through these steps: take from the queue, three reads
// of the single memory read port, compute, load the result; the result is valid as it
// is loaded, and the next request is taken in the cycle after the result is accepted.
// A scale request ranks off-diagonal pairs in turn against all others until it finds
// the upper median, bound by the memory read port. A write completes in the cycle it
// is taken; an out-of-range read goes straight to output. Reset is asynchronous, active
// low; memory is not cleared. A two-entry queue takes requests while a result waits.
module substitution_penalty_table import spt_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [SizeW-1:0]  cfg_data_i,
  spt_req_if.sink                req,
  spt_rsp_if.source              rsp
);
  logic [SizeW-1:0] size_q;
  logic unit_q;
  req_t q_data;
  logic q_valid, q_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(24);
      unit_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegSize) size_q <= cfg_data_i;
      else unit_q <= cfg_data_i[0];
    end
  end

  spt_front u_front (.clk_i, .rst_ni, .req, .q_data_o(q_data), .q_valid_o(q_valid),
                     .q_pop_i(q_pop));
  spt_back u_back (.clk_i, .rst_ni, .size_i(size_q), .unit_i(unit_q), .q_data_i(q_data),
                   .q_valid_i(q_valid), .q_pop_o(q_pop), .rsp);
endmodule
`default_nettype wire

// ----- tb/sv/tb_substitution_penalty_table.sv -----
`timescale 1ns / 100ps

module tb_substitution_penalty_table;
  import spt_pkg::*;

  // Tracks the similarity table and register state, and checks each result in order.
  class penalty_predictor;
    int unsigned size_reg;
    bit unit_sel;
    logic signed [ScoreW-1:0] store [Depth];
    rsp_t pending[$];
    int errors;

    function new();
      size_reg = 24;
      unit_sel = 1'b0;
      errors = 0;
    endfunction

    function int unsigned size_in_use();
      return (size_reg > MaxSize) ? MaxSize : size_reg;
    endfunction

    function int pair_penalty(int unsigned a, int unsigned b);
      int p;
      if (unit_sel) return (a == b) ? 0 : 1;
      p = int'(store[a*MaxSize+a]) + int'(store[b*MaxSize+b]) - 2 * int'(store[a*MaxSize+b]);
      return (p < 0) ? 0 : p;
    endfunction

    // The upper median of all off-diagonal penalties.
    function int median_penalty();
      int pens[$];
      int unsigned n;
      n = size_in_use();
      if (n < 2) return 0;
      for (int unsigned a = 0; a < n; a++)
        for (int unsigned b = 0; b < n; b++)
          if (a != b) pens = {pens, pair_penalty(a, b)};
      pens.sort();
      return pens[pens.size() / 2];
    endfunction

    function void take_request(req_t r);
      rsp_t res;
      int unsigned n;
      n = size_in_use();
      res = '0;
      case (r.cmd)
        CmdWrite: begin
          store[r.row*MaxSize+r.col] = r.value;
        end
        CmdRead: begin
          if (r.row >= n || r.col >= n) begin
            res.out_of_range = 1'b1;
          end else begin
            res.penalty = PenW'(pair_penalty(r.row, r.col));
            if (unit_sel) res.similarity = (r.row == r.col) ? ScoreW'(1) : '0;
            else res.similarity = store[r.row*MaxSize+r.col];
          end
          pending = {pending, res};
        end
        CmdScale: begin
          res.kind = 1'b1;
          res.scale_value = PenW'(median_penalty());
          pending = {pending, res};
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.penalty !== want.penalty) begin
        $display("%0t: penalty expected %0d actual %0d", $time, want.penalty, got.penalty);
        errors++;
      end
      if (got.similarity !== want.similarity) begin
        $display("%0t: similarity expected %0d actual %0d", $time,
                 want.similarity, got.similarity);
        errors++;
      end
      if (got.scale_value !== want.scale_value) begin
        $display("%0t: scale_value expected %0d actual %0d", $time,
                 want.scale_value, got.scale_value);
        errors++;
      end
      if (got.out_of_range !== want.out_of_range) begin
        $display("%0t: out_of_range expected %0d actual %0d", $time,
                 want.out_of_range, got.out_of_range);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [SizeW-1:0] cfg_data_i;
  bit calm;
  bit written [Depth];
  penalty_predictor pred;

  spt_req_if req_ch ();
  spt_rsp_if rsp_ch ();

  substitution_penalty_table u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("substitution_penalty_table verification failed");
    $finish;
  end

  // Response side: random back-pressure unless calm is set, every accepted result is checked.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_ch.valid && rsp_ch.ready) pred.check_result(rsp_ch.data);
      rsp_ch.ready <= calm || ($urandom_range(99) >= 36);
    end
  end

  // Presents one request and waits until it is taken; valid stays high afterwards.
  task automatic send_request(input logic [1:0] cmd, input int unsigned row,
                              input int unsigned col, input logic [ScoreW-1:0] value);
    req_t r;
    r.cmd = cmd;
    r.row = IdxW'(row);
    r.col = IdxW'(col);
    r.value = value;
    if (!calm && $urandom_range(99) < 36) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    do @(posedge clk_i); while (!req_ch.ready);
    if (cmd == CmdWrite) written[row*MaxSize+col] = 1'b1;
    pred.take_request(r);
  endtask

  function automatic logic [ScoreW-1:0] pick_score();
    case ($urandom_range(9))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return ScoreW'($urandom);
    endcase
  endfunction

  task automatic fill_entry(input int unsigned a, input int unsigned b);
    if (!written[a*MaxSize+b]) send_request(CmdWrite, a, b, pick_score());
  endtask

  // A pair read; the entries it touches are loaded first when the table is used.
  task automatic read_pair(input int unsigned a, input int unsigned b);
    int unsigned n;
    n = pred.size_in_use();
    if (!pred.unit_sel && a < n && b < n) begin
      fill_entry(a, a);
      fill_entry(b, b);
      fill_entry(a, b);
    end
    send_request(CmdRead, a, b, ScoreW'($urandom));
  endtask

  task automatic request_scale();
    int unsigned n;
    n = pred.size_in_use();
    if (!pred.unit_sel)
      for (int unsigned a = 0; a < n; a++)
        for (int unsigned b = 0; b < n; b++) fill_entry(a, b);
    send_request(CmdScale, $urandom, $urandom, ScoreW'($urandom));
  endtask

  // Registers change only once the block has drained.
  task automatic set_config(input int unsigned sz, input bit un);
    req_ch.valid <= 1'b0;
    while (pred.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= RegSize;
    cfg_data_i <= SizeW'(sz);
    @(posedge clk_i);
    cfg_idx_i <= RegUnit;
    cfg_data_i <= SizeW'(un);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred.size_reg = sz;
    pred.unit_sel = un;
  endtask

  // Mostly reads inside the table, with writes, scale requests and unused commands mixed in.
  task automatic run_phase(input int unsigned sz, input bit un, input int cnt,
                           input bit scale_ok);
    int unsigned n;
    int unsigned a;
    int unsigned b;
    int pick;
    set_config(sz, un);
    n = pred.size_in_use();
    if (scale_ok) request_scale();
    for (int i = 0; i < cnt; i++) begin
      pick = $urandom_range(99);
      if (n > 0 && $urandom_range(99) < 85) begin
        a = $urandom_range(n - 1);
        b = ($urandom_range(3) == 0) ? a : $urandom_range(n - 1);
      end else begin
        a = $urandom_range(31);
        b = $urandom_range(31);
      end
      if (pick < 65) read_pair(a, b);
      else if (pick < 88) send_request(CmdWrite, $urandom_range(31), $urandom_range(31),
                                       pick_score());
      else if (pick < 93 && scale_ok) request_scale();
      else if (pick < 96) send_request(CmdSpare, a, b, ScoreW'($urandom));
      else read_pair($urandom_range(31), $urandom_range(31));
    end
  endtask

  initial begin
    pred = new();
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegSize;
    cfg_data_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    calm = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks: score extremes, clamping, range edges at reset settings; small sizes.
    send_request(CmdWrite, 0, 0, 16'h7fff);
    send_request(CmdWrite, 1, 1, 16'h8000);
    send_request(CmdWrite, 0, 1, 16'h8000);
    send_request(CmdWrite, 1, 0, 16'h7fff);
    send_request(CmdWrite, 2, 2, 16'h7fff);
    send_request(CmdWrite, 0, 2, 16'h8000);
    send_request(CmdWrite, 31, 31, 16'h0000);
    read_pair(0, 2);
    read_pair(1, 0);
    read_pair(0, 1);
    read_pair(0, 0);
    read_pair(24, 0);
    read_pair(3, 31);
    read_pair(23, 23);
    send_request(CmdSpare, 31, 31, 16'hffff);
    set_config(0, 1'b0);
    request_scale();
    read_pair(0, 0);
    set_config(1, 1'b1);
    request_scale();
    read_pair(0, 0);
    set_config(2, 1'b0);
    request_scale();

    // Random phases over several register settings.
    run_phase(24, 1'b0, 110, 1'b0);
    run_phase(5, 1'b0, 110, 1'b1);
    calm = 1'b1;
    run_phase(32, 1'b0, 110, 1'b0);
    calm = 1'b0;
    run_phase(63, 1'b1, 110, 1'b0);
    run_phase(8, 1'b0, 110, 1'b1);
    run_phase(3, 1'b1, 110, 1'b1);
    run_phase(12, 1'b0, 100, 1'b0);
    request_scale();
    run_phase(6, 1'b0, 110, 1'b1);
    run_phase(7, 1'b1, 110, 1'b1);
    run_phase(2, 1'b0, 100, 1'b1);

    // Drain and finish.
    req_ch.valid <= 1'b0;
    while (pred.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (pred.errors == 0) begin
      $display("substitution_penalty_table verification clean");
    end else begin
      $display("substitution_penalty_table verification failed");
    end
    $finish;
  end
endmodule

// ----- substitution_penalty_table.f -----
+incdir+hdl
hdl/spt_pkg.sv
hdl/spt_if.sv
hdl/spt_front.sv
hdl/spt_back.sv
hdl/substitution_penalty_table.sv
tb/sv/tb_substitution_penalty_table.sv
